// ===== design/fetp_pkg.sv =====
// fetp_pkg: shared constants, types and codes of the escape-time pixel unit
// no dependencies; imported by the channel interfaces and the top level

package fetp_pkg;

  localparam int ROWS     = 512;
  localparam int COLS     = 512;
  localparam int MAX_ITER = 64;

  localparam int ROW_W     = 9;
  localparam int COL_W     = 9;
  localparam int COLOR_W   = 24;
  localparam int CNT_W     = $clog2(MAX_ITER + 1);
  localparam int Q_W       = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // signed q4.28 constants
  localparam logic signed [Q_W-1:0] Q_ONE        = 32'sh1000_0000;
  localparam logic signed [Q_W-1:0] RE_LO_MANDEL = 32'sh1000_0000;
  localparam logic signed [Q_W-1:0] RE_LO_JULIA  = 32'sh1800_0000;
  localparam logic signed [Q_W-1:0] IM_LO        = 32'shE800_0000;

  // per-index step of the linear map: 3.0 / ROWS and 3.0 / COLS, exact for power-of-two sizes
  localparam logic [Q_W-1:0] ROW_STEP = 32'((64'd3 << 28) / ROWS);
  localparam logic [Q_W-1:0] COL_STEP = 32'((64'd3 << 28) / COLS);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_ZOOM         = 3'd1,
    REG_JULIA_RE     = 3'd2,
    REG_JULIA_IM     = 3'd3,
    REG_COLOR_NEAR   = 3'd4,
    REG_COLOR_FAR    = 3'd5,
    REG_COLOR_INSIDE = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RE,
    ST_MAP_IM,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_UPDATE,
    ST_SCALE,
    ST_COLOR,
    ST_DONE
  } state_e;

  localparam logic MODE_MANDEL = 1'b0;
  localparam logic MODE_JULIA  = 1'b1;

endpackage

// ===== design/fetp_pix_if.sv =====
// fetp_pix_if: valid/ready channel carrying one pixel coordinate item
// depends on fetp_pkg for field widths

interface fetp_pix_if import fetp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] pixel_row;
  logic [COL_W-1:0] pixel_col;

  modport source (output valid, output pixel_row, output pixel_col, input ready);
  modport sink   (input valid, input pixel_row, input pixel_col, output ready);
endinterface

// ===== design/fetp_res_if.sv =====
// fetp_res_if: valid/ready channel carrying one colored pixel result item
// depends on fetp_pkg for field widths

interface fetp_res_if import fetp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   out_row;
  logic [COL_W-1:0]   out_col;
  logic [COLOR_W-1:0] pixel_color;
  logic [CNT_W-1:0]   escape_count;
  logic               escaped;

  modport source (output valid, output out_row, output out_col, output pixel_color,
                  output escape_count, output escaped, input ready);
  modport sink   (input valid, input out_row, input out_col, input pixel_color,
                  input escape_count, input escaped, output ready);
endinterface

// ===== design/fetp_cfg_if.sv =====
// fetp_cfg_if: register write channel, index plus data
// depends on fetp_pkg for field widths

interface fetp_cfg_if import fetp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/fractal_escape_time_pixel_unit.sv =====
// fractal_escape_time_pixel_unit: escape-time coloring of one mandelbrot/julia pixel
// depends on fetp_pkg and the fetp_pix_if, fetp_res_if, fetp_cfg_if interfaces
//
// Usage:
//   pix_i  takes one item (pixel_row, pixel_col); ready is high only while idle.
//   res_o  gives one item per pixel: the echoed row/column, the color, the
//          escape iteration (MAX_ITER if none) and the escaped flag.
//   cfg_i  writes a register (index, data) and is always ready; write only
//          while no pixel is in flight. Unknown indexes are ignored.
// Datapath: one 33x33 signed multiplier is shared by every product, so each
//   iteration of z = z*z + c runs three products and then an update in turn.
//   A new pixel is accepted only once the previous one has left the done
//   state into the output register.
// Reset: asynchronous, active low; configuration and control registers return
//   to reset values (mandelbrot, zoom 1.0, near yellow, far blue, inside black), no item held.
// Stall: a finished result sits in the output register; the next pixel can be
//   accepted and computed meanwhile, and its result waits in the done state
//   until the output register is taken.

module fractal_escape_time_pixel_unit import fetp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fetp_cfg_if.sink   cfg_i,
  fetp_pix_if.sink   pix_i,
  fetp_res_if.source res_o
);

  localparam logic signed [31:0] MaxIterDiv = MAX_ITER;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [37:0] v);
    logic signed [Q_W-1:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic                  mode_q;
  logic [Q_W-1:0]        zoom_q;
  logic signed [Q_W-1:0] julia_re_q, julia_im_q;
  logic [COLOR_W-1:0]    color_near_q, color_far_q, color_inside_q;

  state_e state_q, state_d;

  logic [ROW_W-1:0]      row_q;
  logic [COL_W-1:0]      col_q;
  logic signed [Q_W-1:0] map_re_q, map_im_q;
  logic signed [Q_W-1:0] zr_q, zi_q, cr_q, ci_q;
  logic signed [35:0]    sr_q, si_q;
  logic [63:0]           prod_q;
  logic                  first_q;
  logic [CNT_W-1:0]      iter_q;
  logic [COLOR_W-1:0]    color_q;
  logic                  esc_q;

  logic                  res_valid_q;
  logic [ROW_W-1:0]      res_row_q;
  logic [COL_W-1:0]      res_col_q;
  logic [COLOR_W-1:0]    res_color_q;
  logic [CNT_W-1:0]      res_count_q;
  logic                  res_esc_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  logic                  pix_accept;
  logic                  out_free;
  logic signed [35:0]    prod_fl;
  logic signed [Q_W-1:0] prod_sat;
  logic signed [36:0]    mag;
  logic                  mag_over;
  logic                  last_iter;
  logic signed [Q_W-1:0] re_lo;
  logic signed [Q_W-1:0] map_re_d, map_im_d;
  logic signed [24:0]    color_diff;
  logic signed [31:0]    color_step;

  assign pix_accept = pix_i.valid && pix_i.ready;
  assign out_free   = !res_valid_q || res_o.ready;
  assign prod_fl    = $signed(prod_q[63:28]);
  assign prod_sat   = sat_q(38'(prod_fl));
  assign mag        = 37'(sr_q) + 37'(prod_fl);
  assign mag_over   = mag > 37'sd1073741824;
  assign last_iter  = iter_q == CNT_W'(MAX_ITER - 1);
  assign mul_p      = 66'(mul_a) * 66'(mul_b);

  assign re_lo    = (mode_q == MODE_JULIA) ? RE_LO_JULIA : RE_LO_MANDEL;
  assign map_re_d = re_lo - $signed(32'(32'(pix_i.pixel_row) * ROW_STEP));
  assign map_im_d = IM_LO + $signed(32'(32'(pix_i.pixel_col) * COL_STEP));

  assign color_diff = $signed({1'b0, color_far_q}) - $signed({1'b0, color_near_q});
  assign color_step = $signed(prod_q[31:0]) / MaxIterDiv;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (pix_i.valid) state_d = ST_MAP_RE;
      ST_MAP_RE: state_d = ST_MAP_IM;
      ST_MAP_IM: state_d = ST_SQ_RE;
      ST_SQ_RE:  state_d = ST_SQ_IM;
      ST_SQ_IM:  state_d = ST_CROSS;
      ST_CROSS: begin
        if (first_q) begin
          state_d = ST_UPDATE;
        end else if (mag_over) begin
          state_d = ST_SCALE;
        end else if (last_iter) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_SQ_RE;
      ST_SCALE:  state_d = ST_COLOR;
      ST_COLOR:  state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and multiplier operand select
  always_comb begin
    pix_i.ready = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    case (state_q)
      ST_IDLE:   pix_i.ready = 1'b1;
      ST_MAP_RE: begin
        mul_a = 33'(map_re_q);
        mul_b = $signed({1'b0, zoom_q});
      end
      ST_MAP_IM: begin
        mul_a = 33'(map_im_q);
        mul_b = $signed({1'b0, zoom_q});
      end
      ST_SQ_RE: begin
        mul_a = 33'(zr_q);
        mul_b = 33'(zr_q);
      end
      ST_SQ_IM: begin
        mul_a = 33'(zi_q);
        mul_b = 33'(zi_q);
      end
      ST_CROSS: begin
        mul_a = 33'(zr_q);
        mul_b = 33'(zi_q);
      end
      ST_SCALE: begin
        mul_a = 33'(color_diff);
        mul_b = 33'($signed({1'b0, iter_q}));
      end
      default: begin
        pix_i.ready = 1'b0;
      end
    endcase
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_MANDEL;
      zoom_q         <= 32'h1000_0000;
      julia_re_q     <= '0;
      julia_im_q     <= '0;
      color_near_q   <= 24'hFFFF00;
      color_far_q    <= 24'h0000FF;
      color_inside_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MODE:         mode_q         <= cfg_i.data[0];
        REG_ZOOM:         zoom_q         <= cfg_i.data;
        REG_JULIA_RE:     julia_re_q     <= $signed(cfg_i.data);
        REG_JULIA_IM:     julia_im_q     <= $signed(cfg_i.data);
        REG_COLOR_NEAR:   color_near_q   <= cfg_i.data[COLOR_W-1:0];
        REG_COLOR_FAR:    color_far_q    <= cfg_i.data[COLOR_W-1:0];
        REG_COLOR_INSIDE: color_inside_q <= cfg_i.data[COLOR_W-1:0];
        default:          mode_q         <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      first_q     <= 1'b0;
      iter_q      <= '0;
    end else begin
      state_q <= state_d;
      if (res_valid_q && res_o.ready) res_valid_q <= 1'b0;
      if (state_q == ST_DONE && out_free) res_valid_q <= 1'b1;
      if (pix_accept) begin
        first_q <= 1'b1;
        iter_q  <= '0;
      end else if (state_q == ST_CROSS) begin
        first_q <= 1'b0;
        if (!first_q && !mag_over && !last_iter) iter_q <= iter_q + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[63:0];
    if (pix_accept) begin
      row_q    <= pix_i.pixel_row;
      col_q    <= pix_i.pixel_col;
      map_re_q <= map_re_d;
      map_im_q <= map_im_d;
    end
    case (state_q)
      ST_MAP_IM: zr_q <= prod_sat;
      ST_SQ_RE: begin
        if (first_q) begin
          zi_q <= prod_sat;
          cr_q <= (mode_q == MODE_JULIA) ? julia_re_q : zr_q;
          ci_q <= (mode_q == MODE_JULIA) ? julia_im_q : prod_sat;
        end
      end
      ST_SQ_IM: sr_q <= prod_fl;
      ST_CROSS: begin
        si_q <= prod_fl;
        if (!first_q) begin
          esc_q   <= mag_over;
          color_q <= color_inside_q;
        end
      end
      ST_UPDATE: begin
        zr_q <= sat_q(38'(sr_q) - 38'(si_q) + 38'(cr_q));
        zi_q <= sat_q((38'(prod_fl) <<< 1) + 38'(ci_q));
      end
      ST_COLOR: color_q <= color_near_q + color_step[COLOR_W-1:0];
      default: begin
        sr_q <= sr_q;
      end
    endcase
    if (state_q == ST_DONE && out_free) begin
      res_row_q   <= row_q;
      res_col_q   <= col_q;
      res_color_q <= color_q;
      res_count_q <= esc_q ? iter_q : CNT_W'(MAX_ITER);
      res_esc_q   <= esc_q;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.out_row      = res_row_q;
  assign res_o.out_col      = res_col_q;
  assign res_o.pixel_color  = res_color_q;
  assign res_o.escape_count = res_count_q;
  assign res_o.escaped      = res_esc_q;

`ifndef SYNTHESIS
  a_accept_starts_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_accept |=> state_q == ST_MAP_RE)
    else $error("accepted item did not start the coordinate map");

  a_count_matches_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_esc_q != (res_count_q == CNT_W'(MAX_ITER))))
    else $error("escape count and escaped flag disagree");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> iter_q < CNT_W'(MAX_ITER))
    else $error("iteration counter out of range");

  a_inside_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_esc_q |-> res_color_q == color_inside_q)
    else $error("non-escaped pixel without the inside color");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.ready |=> res_valid_q && $stable(res_color_q))
    else $error("pending result overwritten");
`endif

endmodule
